### rtl/conv2d_multichannel_relu_core_macros.svh
// Assertion helpers for the convolution core.
`ifndef CONV2D_MULTICHANNEL_RELU_CORE_MACROS_SVH
`define CONV2D_MULTICHANNEL_RELU_CORE_MACROS_SVH
// Implication checked every clock outside reset.
`define C2D_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define C2D_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Types and constants shared by the convolution core and its interfaces.
// ----------------------------------------------------------------------------
package c2d_pkg;
  localparam int MaxInCh  = 8;
  localparam int MaxOutCh = 8;
  localparam int MaxKernel = 5;
  localparam int MaxSide  = 32;
  localparam int ImgDepth = MaxInCh * MaxSide * MaxSide;
  localparam int WgtDepth = MaxOutCh * MaxInCh * MaxKernel * MaxKernel;
  localparam int ImgAw = $clog2(ImgDepth);
  localparam int WgtAw = $clog2(WgtDepth);

  typedef enum logic [1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_BIAS    = 2'd1,
    REQ_SAMPLE  = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_IN_CH   = 3'd0,
    CFG_OUT_CH  = 3'd1,
    CFG_K_ROWS  = 3'd2,
    CFG_K_COLS  = 3'd3,
    CFG_I_ROWS  = 3'd4,
    CFG_I_COLS  = 3'd5,
    CFG_RELU    = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MAC, ST_BIAS, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  out_chan;
    logic [2:0]  in_chan;
    logic [4:0]  row;
    logic [4:0]  col;
    logic signed [15:0] sample_value;
    logic signed [31:0] bias_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic        saturated;
    logic        bad_position;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_word_t;
endpackage

### rtl/c2d_stream_if.sv
// ----------------------------------------------------------------------------
// c2d_stream_if
// Valid/ready channels for input, result and configuration words.
// ----------------------------------------------------------------------------
interface c2d_in_if;
  import c2d_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c2d_out_if;
  import c2d_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c2d_cfg_if;
  import c2d_pkg::*;
  logic valid;
  logic ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/conv2d_multichannel_relu_core.sv
// ----------------------------------------------------------------------------
// conv2d_multichannel_relu_core
// Valid multi-channel 2D convolution with bias and optional ReLU.
// ----------------------------------------------------------------------------
// Usage:
//   in_  : request words. Loads (weight, bias, sample) write a store and
//          give no result. A compute word gives one result word.
//   out_ : result words (Q16.16 value, saturated and bad_position flags).
//   cfg_ : register writes (index, data). Always ready; write only while the
//          core is idle and no result word waits.
// A compute uses one shared 16x16 multiplier and 48-bit accumulator that
//   handle one tap per cycle, set by the single read port of the sample and
//   weight memories. An invalid position skips the reads and goes straight
//   to the done state.
// in_ready is low from a compute word's acceptance until its result is
// taken; a stalled out_ side simply holds the result register.
// Reset (rst_n low, synchronous) restores register defaults and returns the
// sequencer to idle. Stores are not cleared; the user must see that entries
// are read only after being written; the block does not enforce it.
// ----------------------------------------------------------------------------
module conv2d_multichannel_relu_core (
  input logic clk,
  input logic rst_n,
  c2d_in_if.sink   in_ch,
  c2d_out_if.source out_ch,
  c2d_cfg_if.sink  cfg_ch
);
  import c2d_pkg::*;

  // configuration registers, raw bits
  logic [3:0] in_channels_r, out_channels_r;
  logic [2:0] kernel_rows_r, kernel_cols_r;
  logic [5:0] image_rows_r, image_cols_r;
  logic       relu_r;

  // stores
  logic signed [15:0] img_mem [ImgDepth];
  logic signed [15:0] wgt_mem [WgtDepth];
  logic signed [31:0] bias_mem [MaxOutCh];

  state_t state_r, state_nxt;
  logic [2:0] oc_r;
  logic [4:0] row_r, col_r;
  logic [2:0] ch_r;
  logic [2:0] ka_r, kb_r;
  logic       last_rd_r;     // the read just issued is the final tap
  logic       mac_en_r;
  logic signed [15:0] w_q, s_q;
  logic signed [47:0] acc_r;
  logic signed [31:0] prod_r;
  logic       prod_v_r, prod_last_r;
  out_word_t  res_r;
  logic       out_valid_r;

  // effective (clamped) configuration
  logic [3:0] nic;
  logic [3:0] noc;
  logic [2:0] kr, kc;
  logic [5:0] ir, icl;
  assign nic = (in_channels_r == 4'd0) ? 4'd1 :
               (in_channels_r > 4'(MaxInCh)) ? 4'(MaxInCh) : in_channels_r;
  assign noc = (out_channels_r == 4'd0) ? 4'd1 :
               (out_channels_r > 4'(MaxOutCh)) ? 4'(MaxOutCh) : out_channels_r;
  assign kr  = (kernel_rows_r == 3'd0) ? 3'd1 :
               (kernel_rows_r > 3'(MaxKernel)) ? 3'(MaxKernel) : kernel_rows_r;
  assign kc  = (kernel_cols_r == 3'd0) ? 3'd1 :
               (kernel_cols_r > 3'(MaxKernel)) ? 3'(MaxKernel) : kernel_cols_r;
  assign ir  = (image_rows_r == 6'd0) ? 6'd1 :
               (image_rows_r > 6'(MaxSide)) ? 6'(MaxSide) : image_rows_r;
  assign icl = (image_cols_r == 6'd0) ? 6'd1 :
               (image_cols_r > 6'(MaxSide)) ? 6'(MaxSide) : image_cols_r;

  in_word_t iw;
  assign iw = in_ch.data;
  logic in_acc;
  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  logic out_acc;
  assign out_acc = out_valid_r && out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;
  assign cfg_ch.ready = 1'b1;

  logic bad_pos;
  assign bad_pos = ({1'b0, iw.out_chan} >= noc) || ({3'b0, kr} > ir) ||
                   ({3'b0, kc} > icl) ||
                   ({1'b0, iw.row} > (ir - {3'b0, kr})) ||
                   ({1'b0, iw.col} > (icl - {3'b0, kc}));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_channels_r <= 4'd1;
      out_channels_r <= 4'd1;
      kernel_rows_r <= 3'd3;
      kernel_cols_r <= 3'd3;
      image_rows_r <= 6'd32;
      image_cols_r <= 6'd32;
      relu_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.data.index))
        CFG_IN_CH:  in_channels_r <= cfg_ch.data.data[3:0];
        CFG_OUT_CH: out_channels_r <= cfg_ch.data.data[3:0];
        CFG_K_ROWS: kernel_rows_r <= cfg_ch.data.data[2:0];
        CFG_K_COLS: kernel_cols_r <= cfg_ch.data.data[2:0];
        CFG_I_ROWS: image_rows_r <= cfg_ch.data.data[5:0];
        CFG_I_COLS: image_cols_r <= cfg_ch.data.data[5:0];
        CFG_RELU:   relu_r <= cfg_ch.data.data[0];
        default: ;
      endcase
    end
  end

  // store writes and registered reads
  logic [ImgAw-1:0] img_ra, img_wa;
  logic [WgtAw-1:0] wgt_ra, wgt_wa;
  assign img_wa = ImgAw'(({10'd0, iw.in_chan} * MaxSide + iw.row) * MaxSide + iw.col);
  assign wgt_wa = WgtAw'((({8'd0, iw.out_chan} * MaxInCh + iw.in_chan) * MaxKernel
                  + iw.row) * MaxKernel + iw.col);
  assign img_ra = ImgAw'(({10'd0, ch_r} * MaxSide + (row_r + ka_r)) * MaxSide
                  + (col_r + kb_r));
  assign wgt_ra = WgtAw'((({8'd0, oc_r} * MaxInCh + ch_r) * MaxKernel + ka_r)
                  * MaxKernel + kb_r);

  always_ff @(posedge clk) begin
    if (in_acc && iw.req_type == REQ_SAMPLE)
      img_mem[img_wa] <= iw.sample_value;
    if (in_acc && iw.req_type == REQ_WEIGHT && iw.row < 5'(MaxKernel) &&
        iw.col < 5'(MaxKernel))
      wgt_mem[wgt_wa] <= iw.sample_value;
    if (in_acc && iw.req_type == REQ_BIAS)
      bias_mem[iw.out_chan] <= iw.bias_value;
    s_q <= img_mem[img_ra];
    w_q <= wgt_mem[wgt_ra];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && iw.req_type == REQ_COMPUTE)
                 state_nxt = bad_pos ? ST_DONE : ST_READ;
      ST_READ: if (last_rd_r) state_nxt = ST_MAC;
      ST_MAC:  if (prod_v_r && prod_last_r) state_nxt = ST_BIAS;
      ST_BIAS: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic tap_last;
  assign tap_last = (kb_r == kc - 3'd1) && (ka_r == kr - 3'd1) &&
                    ({1'b0, ch_r} == nic - 4'd1);

  logic signed [47:0] acc_b;
  logic signed [31:0] sat_v;
  logic sat_f;
  assign acc_b = acc_r + 48'(bias_mem[oc_r]);
  always_comb begin
    sat_f = 1'b0;
    sat_v = acc_b[31:0];
    if (acc_b > 48'sh7FFFFFFF) begin
      sat_v = 32'sh7FFFFFFF; sat_f = 1'b1;
    end else if (acc_b < -48'sh80000000) begin
      sat_v = 32'sh80000000; sat_f = 1'b1;
    end
    if (relu_r && sat_v < 0) sat_v = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      mac_en_r <= 1'b0;
      prod_v_r <= 1'b0;
      last_rd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) out_valid_r <= 1'b0;
      // read tap counters walk kb, ka, ch
      mac_en_r <= (state_r == ST_READ) && !last_rd_r;
      prod_v_r <= mac_en_r;
      prod_last_r <= mac_en_r && last_rd_r;
      if (state_r == ST_IDLE && in_acc) begin
        oc_r <= iw.out_chan; row_r <= iw.row; col_r <= iw.col;
        ch_r <= '0; ka_r <= '0; kb_r <= '0;
        acc_r <= '0;
        last_rd_r <= 1'b0;
        if (iw.req_type == REQ_COMPUTE && bad_pos)
          res_r <= '{result_value: '0, saturated: 1'b0, bad_position: 1'b1};
      end else if (state_r == ST_READ && !last_rd_r) begin
        if (tap_last) last_rd_r <= 1'b1;
        else if (kb_r != kc - 3'd1) kb_r <= kb_r + 3'd1;
        else begin
          kb_r <= '0;
          if (ka_r != kr - 3'd1) ka_r <= ka_r + 3'd1;
          else begin ka_r <= '0; ch_r <= ch_r + 3'd1; end
        end
      end
      if (mac_en_r) prod_r <= w_q * s_q;
      if (prod_v_r) acc_r <= acc_r + 48'(prod_r);
      if (state_r == ST_BIAS)
        res_r <= '{result_value: sat_v, saturated: sat_f, bad_position: 1'b0};
      if (state_r == ST_DONE) out_valid_r <= 1'b1;
    end
  end

  `include "conv2d_multichannel_relu_core_macros.svh"
  `C2D_ASSERT_IMP(a_busy_no_ready, state_r != ST_IDLE, !in_ch.ready)
  `C2D_ASSERT_NXT(a_done_shows, state_r == ST_DONE, out_valid_r)
  `C2D_ASSERT_IMP(a_bad_zero, out_valid_r && res_r.bad_position,
                  res_r.result_value == 0 && !res_r.saturated)
endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives request, result and register channels of the convolution core.
// Predicts each result in a scoreboard and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import c2d_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 260;   // longest compute plus margin
  localparam int LongHold = 400;       // receiver hold-off that backs up the core
  localparam int WinSide = 6;          // image rows/cols that computes may read

  // Scoreboard: own copy of stores and registers, queue of expected words.
  class conv_scoreboard;
    shortint img[ImgDepth];
    shortint wgt[WgtDepth];
    int bias[MaxOutCh];
    int unsigned regs[7];
    out_word_t expected[$];
    int errors;

    function new();
      regs = '{1, 1, 3, 3, 32, 32, 0};
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_IN_CH, CFG_OUT_CH: regs[idx] = data[3:0];
        CFG_K_ROWS, CFG_K_COLS: regs[idx] = data[2:0];
        CFG_I_ROWS, CFG_I_COLS: regs[idx] = data[5:0];
        CFG_RELU: regs[idx] = data[0];
        default: ;
      endcase
    endfunction

    // Effective register value: zero reads as 1, above max reads as max.
    function int eff(cfg_idx_t idx);
      int hi;
      case (idx)
        CFG_IN_CH: hi = MaxInCh;
        CFG_OUT_CH: hi = MaxOutCh;
        CFG_K_ROWS, CFG_K_COLS: hi = MaxKernel;
        default: hi = MaxSide;
      endcase
      if (regs[idx] < 1) return 1;
      if (regs[idx] > hi) return hi;
      return regs[idx];
    endfunction

    function int wgt_at(int oc, int ic, int r, int c);
      return ((oc * MaxInCh + ic) * MaxKernel + r) * MaxKernel + c;
    endfunction

    function void note_request(in_word_t w);
      int nic, noc, kr, kc, ir, icl;
      longint acc;
      out_word_t exp_w;
      case (req_t'(w.req_type))
        REQ_WEIGHT: begin
          if (w.row < MaxKernel && w.col < MaxKernel)
            wgt[wgt_at(w.out_chan, w.in_chan, w.row, w.col)] = w.sample_value;
        end
        REQ_BIAS: bias[w.out_chan] = w.bias_value;
        REQ_SAMPLE: img[(w.in_chan * MaxSide + w.row) * MaxSide + w.col] = w.sample_value;
        default: begin
          nic = eff(CFG_IN_CH);
          noc = eff(CFG_OUT_CH);
          kr = eff(CFG_K_ROWS);
          kc = eff(CFG_K_COLS);
          ir = eff(CFG_I_ROWS);
          icl = eff(CFG_I_COLS);
          exp_w = '0;
          if (w.out_chan >= noc || kr > ir || kc > icl ||
              int'(w.row) > ir - kr || int'(w.col) > icl - kc) begin
            exp_w.bad_position = 1'b1;
          end else begin
            acc = 0;
            for (int ch = 0; ch < nic; ch++)
              for (int a = 0; a < kr; a++)
                for (int b = 0; b < kc; b++)
                  acc += longint'(wgt[wgt_at(w.out_chan, ch, a, b)]) *
                         longint'(img[(ch * MaxSide + w.row + a) * MaxSide + w.col + b]);
            acc += longint'(bias[w.out_chan]);
            if (acc > 64'sh7FFF_FFFF) begin
              acc = 64'sh7FFF_FFFF;
              exp_w.saturated = 1'b1;
            end
            if (acc < -64'sh8000_0000) begin
              acc = -64'sh8000_0000;
              exp_w.saturated = 1'b1;
            end
            // ReLU acts on the clamped value; saturated flag survives it
            if (regs[CFG_RELU] != 0 && acc < 0) acc = 0;
            exp_w.result_value = acc[31:0];
          end
          expected = {expected, exp_w};
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      want = expected.pop_front();
      if (got.result_value !== want.result_value)
        report($sformatf("result_value %h, want %h", got.result_value, want.result_value));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
      if (got.bad_position !== want.bad_position)
        report($sformatf("bad_position %b, want %b", got.bad_position, want.bad_position));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  c2d_in_if in_if();
  c2d_out_if out_if();
  c2d_cfg_if cfg_if();

  conv2d_multichannel_relu_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  conv_scoreboard sb = new();

  // Which store entries hold a value; computes only read loaded entries.
  bit img_loaded[ImgDepth];
  bit wgt_loaded[WgtDepth];
  bit bias_loaded[MaxOutCh];

  int tx_burst_left = 0;
  int rx_burst_left = 0;
  int rx_wait = 0;
  bit long_hold_req = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: check each accepted word, then draw the gap before the next.
  // A long hold-off requested by the stimulus is counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.data);
        if (rx_burst_left > 0) begin
          rx_wait = 0;
          rx_burst_left--;
        end else begin
          rx_wait = $urandom_range(0, 6);
          if ($urandom_range(0, 20) == 0) rx_burst_left = $urandom_range(5, 30);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_wait = LongHold;
      end
      out_if.ready <= (rx_wait == 0);
      if (rx_wait > 0) rx_wait--;
    end
  end

  function automatic int wgt_index(int oc, int ic, int r, int c);
    return ((oc * MaxInCh + ic) * MaxKernel + r) * MaxKernel + c;
  endfunction

  function automatic int img_index(int ic, int r, int c);
    return (ic * MaxSide + r) * MaxSide + c;
  endfunction

  // Mostly small Q8.8 values so sums stay in range; some full range and extremes.
  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom());
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic logic [31:0] draw_bias();
    if ($urandom_range(0, 2) == 0) return $urandom();
    return 32'($urandom_range(0, 2000000) - 1000000);
  endfunction

  function automatic in_word_t make_word(req_t req, int oc, int ic, int r, int c,
                                         logic [15:0] sv, logic [31:0] bv);
    in_word_t w;
    w.req_type = req;
    w.out_chan = 3'(oc);
    w.in_chan = 3'(ic);
    w.row = 5'(r);
    w.col = 5'(c);
    w.sample_value = sv;
    w.bias_value = bv;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    if (tx_burst_left > 0) begin
      gap = 0;
      tx_burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 30) == 0) tx_burst_left = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(w);
    case (req_t'(w.req_type))
      REQ_WEIGHT: if (w.row < MaxKernel && w.col < MaxKernel)
        wgt_loaded[wgt_index(w.out_chan, w.in_chan, w.row, w.col)] = 1'b1;
      REQ_BIAS: bias_loaded[w.out_chan] = 1'b1;
      REQ_SAMPLE: img_loaded[img_index(w.in_chan, w.row, w.col)] = 1'b1;
      default: ;
    endcase
  endtask

  // Stop offering words and wait until every result is back and the core is idle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_config(int n_in, int n_out, int kr, int kc, int ir, int icl,
                              int relu);
    int vals[7];
    vals = '{n_in, n_out, kr, kc, ir, icl, relu};
    for (int i = 0; i < 7; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data <= {3'(i), 32'(vals[i])};
      do @(posedge clk); while (!cfg_if.ready);
      sb.set_reg(cfg_idx_t'(i), 32'(vals[i]));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Load every weight and bias the current setting can read, and the samples of
  // the image corner that computes use, if missing.
  task automatic load_missing();
    int nic, noc, kr, kc, wr, wc;
    nic = sb.eff(CFG_IN_CH);
    noc = sb.eff(CFG_OUT_CH);
    kr = sb.eff(CFG_K_ROWS);
    kc = sb.eff(CFG_K_COLS);
    wr = (sb.eff(CFG_I_ROWS) < WinSide) ? sb.eff(CFG_I_ROWS) : WinSide;
    wc = (sb.eff(CFG_I_COLS) < WinSide) ? sb.eff(CFG_I_COLS) : WinSide;
    for (int oc = 0; oc < noc; oc++) begin
      if (!bias_loaded[oc])
        send_word(make_word(REQ_BIAS, oc, $urandom_range(0, 7), $urandom(), $urandom(),
                            draw_sample(), draw_bias()));
      for (int ic = 0; ic < nic; ic++)
        for (int a = 0; a < kr; a++)
          for (int b = 0; b < kc; b++)
            if (!wgt_loaded[wgt_index(oc, ic, a, b)])
              send_word(make_word(REQ_WEIGHT, oc, ic, a, b, draw_sample(), $urandom()));
    end
    for (int ic = 0; ic < nic; ic++)
      for (int r = 0; r < wr; r++)
        for (int c = 0; c < wc; c++)
          if (!img_loaded[img_index(ic, r, c)])
            send_word(make_word(REQ_SAMPLE, $urandom_range(0, 7), ic, r, c, draw_sample(),
                                $urandom()));
  endtask

  // Random traffic: loads anywhere (some outside the weight store, so ignored)
  // and computes, mostly at valid positions inside the loaded image corner.
  task automatic random_items(int count);
    in_word_t w;
    int noc, kr, kc, ir, icl, wr, wc;
    noc = sb.eff(CFG_OUT_CH);
    kr = sb.eff(CFG_K_ROWS);
    kc = sb.eff(CFG_K_COLS);
    ir = sb.eff(CFG_I_ROWS);
    icl = sb.eff(CFG_I_COLS);
    wr = (ir < WinSide) ? ir : WinSide;
    wc = (icl < WinSide) ? icl : WinSide;
    for (int n = 0; n < count; n++) begin
      w.req_type = REQ_SAMPLE;
      w.out_chan = 3'($urandom());
      w.in_chan = 3'($urandom());
      w.row = 5'($urandom());
      w.col = 5'($urandom());
      w.bias_value = $urandom();
      w.sample_value = draw_sample();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          w.req_type = REQ_WEIGHT;
          if ($urandom_range(0, 3) != 0) begin
            w.row = 5'($urandom_range(0, MaxKernel - 1));
            w.col = 5'($urandom_range(0, MaxKernel - 1));
          end
        end
        3: begin
          w.req_type = REQ_BIAS;
          w.bias_value = draw_bias();
        end
        4, 5: w.req_type = REQ_SAMPLE;
        default: begin
          w.req_type = REQ_COMPUTE;
          if ($urandom_range(0, 3) != 0 && kr <= ir && kc <= icl) begin
            w.out_chan = 3'($urandom_range(0, noc - 1));
            w.row = 5'($urandom_range(0, wr - kr));
            w.col = 5'($urandom_range(0, wc - kc));
          end else if (int'(w.out_chan) < noc && kr <= ir && kc <= icl &&
                       int'(w.row) <= ir - kr && int'(w.col) <= icl - kc) begin
            // a valid position must stay inside the loaded corner
            w.row = 5'(int'(w.row) % (wr - kr + 1));
            w.col = 5'(int'(w.col) % (wc - kc + 1));
          end
        end
      endcase
      send_word(w);
    end
  endtask

  task automatic directed_items();
    // Setting here: one input channel, four outputs, 1x1 kernel, 1x1 image, ReLU on.
    send_word(make_word(REQ_WEIGHT, 0, 0, 0, 0, 16'h8000, 0));
    send_word(make_word(REQ_SAMPLE, 0, 0, 0, 0, 16'h8000, 0));
    send_word(make_word(REQ_BIAS, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send_word(make_word(REQ_COMPUTE, 0, 0, 0, 0, 0, 0));     // clamps high
    send_word(make_word(REQ_WEIGHT, 1, 0, 0, 0, 16'h7FFF, 0));
    send_word(make_word(REQ_BIAS, 1, 0, 0, 0, 0, 32'h8000_0000));
    send_word(make_word(REQ_COMPUTE, 1, 0, 0, 0, 0, 0));     // clamps low, then ReLU to 0
    send_word(make_word(REQ_WEIGHT, 2, 0, 0, 0, 16'h0000, 0));
    send_word(make_word(REQ_BIAS, 2, 0, 0, 0, 0, -32'sd5));
    send_word(make_word(REQ_COMPUTE, 2, 0, 0, 0, 0, 0));     // ReLU clamp, no flag
    send_word(make_word(REQ_WEIGHT, 3, 0, 0, 0, 16'h0100, 0));
    send_word(make_word(REQ_BIAS, 3, 0, 0, 0, 0, 32'h0001_0000));
    send_word(make_word(REQ_COMPUTE, 3, 7, 0, 0, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(REQ_COMPUTE, 0, 0, 1, 0, 0, 0));     // row off the image
    send_word(make_word(REQ_COMPUTE, 0, 0, 0, 1, 0, 0));     // col off the image
    send_word(make_word(REQ_COMPUTE, 4, 0, 0, 0, 0, 0));     // channel not in use
    send_word(make_word(REQ_COMPUTE, 7, 7, 31, 31, 0, 0));
    // weight indices beyond the store are dropped
    send_word(make_word(REQ_WEIGHT, 0, 0, 5, 0, 16'h1234, 0));
    send_word(make_word(REQ_WEIGHT, 0, 0, 0, 31, 16'h1234, 0));
    send_word(make_word(REQ_WEIGHT, 7, 7, 31, 31, 16'h7FFF, 0));
    send_word(make_word(REQ_COMPUTE, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_SAMPLE, 7, 7, 31, 31, 16'h7FFF, 0));
    send_word(make_word(REQ_BIAS, 7, 0, 0, 0, 0, 32'h8000_0000));
  endtask

  initial begin
    int n_in, n_out, kr, kc, ir, icl;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: 3x3 kernel over a 32x32 single-channel image.
    load_missing();
    random_items(20);
    drain();

    write_config(1, 4, 1, 1, 1, 1, 1);
    load_missing();
    directed_items();
    drain();

    // Largest tap count: eight channels under a 5x5 kernel.
    write_config(8, 1, 5, 5, 5, 5, 0);
    load_missing();
    random_items(30);
    drain();

    // Out-of-range register values clamp: 1 in, 8 out, 1x5 kernel, 32x6 image.
    write_config(0, 15, 0, 7, 63, 6, 1);
    load_missing();
    random_items(25);
    drain();

    // Kernel taller than the image: every compute is a bad position.
    write_config(2, 2, 5, 5, 3, 40, 0);
    random_items(20);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 9))
        0: n_in = 0;
        default: n_in = $urandom_range(1, 3);
      endcase
      n_out = $urandom_range(0, 3);
      kr = $urandom_range(0, 3);
      kc = $urandom_range(0, 3);
      ir = $urandom_range(0, 10);
      icl = $urandom_range(0, 10);
      write_config(n_in, n_out, kr, kc, ir, icl, $urandom_range(0, 1));
      load_missing();
      if (ph == 0) begin
        // hold the result side off so the core backs up into the request side
        long_hold_req = 1'b1;
        random_items(20);
        drain();
        random_items(10);
      end else if (ph == 1) begin
        random_items(10);
        drain();   // sender pauses until everything is back
        random_items(10);
      end else begin
        random_items(20);
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
